/* hw/rtl/dtt_pkg.sv */
// Shared types, constants and a helper function of the dirty tile tracker.
package dtt_pkg;

  localparam int TILE_SIZE_DEF     = 64;
  localparam int MAX_TILE_COLS_DEF = 64;
  localparam int MAX_TILE_ROWS_DEF = 64;

  localparam int COORD_W  = 14;
  localparam int PIX_W    = 13;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 6;
  localparam int MASK_W   = 64;
  localparam int MODE_W   = 2;
  localparam int DIV_IN_W = 14;
  localparam int DIV_MW   = DIV_IN_W + 1;
  localparam int QUOT_W   = 11;

  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;
  localparam int REG_LSB = 2;
  localparam int REG_W   = APB_AW - REG_LSB;

  localparam logic [REG_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [REG_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [REG_W-1:0] REG_HAS_LAYERS    = 2'd2;

  localparam int CMDQ_AW     = 1;
  localparam int CMDQ_DEPTH  = 1 << CMDQ_AW;
  localparam int OFIFO_AW    = 2;
  localparam int OFIFO_DEPTH = 1 << OFIFO_AW;

  typedef enum logic [MODE_W-1:0] {
    MODE_MARK_RECT = 2'd0,
    MODE_MARK_ALL  = 2'd1,
    MODE_MARK_TILE = 2'd2,
    MODE_COLLECT   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_EMPTY     = 2'd0,
    OP_MARK_ROWS = 2'd1,
    OP_MARK_ALL  = 2'd2,
    OP_COLLECT   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] row_first;
    logic [IDX_W-1:0] row_last;
    logic [MASK_W-1:0] mask;
  } cmd_t;

  typedef struct packed {
    logic             canvas;
    logic             has_layers;
    logic [CNT_W-1:0] cols;
    logic [CNT_W-1:0] rows;
  } grid_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row_index;
    logic [MASK_W-1:0] dirty_mask;
    logic              last;
  } res_t;

  // Division by a constant through a multiply by its scaled reciprocal.
  function automatic logic [QUOT_W-1:0] recip_div(input logic [DIV_IN_W-1:0] v,
                                                  input logic [DIV_MW-1:0] m,
                                                  input int s);
    logic [DIV_IN_W+DIV_MW-1:0] p;
    p = (DIV_IN_W + DIV_MW)'(v) * (DIV_IN_W + DIV_MW)'(m);
    return QUOT_W'(p >> s);
  endfunction

endpackage

/* hw/rtl/dtt_cfg.sv */
// Configuration registers and derived tile grid size of the dirty tile tracker.
module dtt_cfg #(
  parameter int TILE_SIZE     = dtt_pkg::TILE_SIZE_DEF,
  parameter int MAX_TILE_COLS = dtt_pkg::MAX_TILE_COLS_DEF,
  parameter int MAX_TILE_ROWS = dtt_pkg::MAX_TILE_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dtt_pkg::APB_AW-1:0]  paddr,
  input  logic [dtt_pkg::APB_DW-1:0]  pwdata,
  output logic [dtt_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output dtt_pkg::grid_t              grid,
  output logic                        resize
);
  import dtt_pkg::*;

  localparam int DIV_L = $clog2(TILE_SIZE);
  localparam int DIV_S = DIV_IN_W + DIV_L;
  localparam longint DIV_M_FULL =
    ((longint'(1) << DIV_S) + longint'(TILE_SIZE) - 1) / longint'(TILE_SIZE);
  localparam logic [DIV_MW-1:0] DIV_M = DIV_MW'(DIV_M_FULL);

  logic [PIX_W-1:0] width_r, height_r;
  logic             layers_r;
  logic             resize_r;
  logic [CNT_W-1:0] cols_r, rows_r;
  logic [CNT_W-1:0] cols_nxt, rows_nxt;
  logic [QUOT_W-1:0] cols_q, rows_q;
  logic             wr_en;
  logic [REG_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:REG_LSB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      layers_r <= 1'b0;
      resize_r <= 1'b0;
    end else begin
      resize_r <= 1'b0;
      if (wr_en) begin
        case (reg_idx)
          REG_CANVAS_WIDTH: begin
            width_r  <= pwdata[PIX_W-1:0];
            resize_r <= 1'b1;
          end
          REG_CANVAS_HEIGHT: begin
            height_r <= pwdata[PIX_W-1:0];
            resize_r <= 1'b1;
          end
          REG_HAS_LAYERS: begin
            layers_r <= pwdata[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CANVAS_WIDTH:  prdata = APB_DW'(width_r);
      REG_CANVAS_HEIGHT: prdata = APB_DW'(height_r);
      REG_HAS_LAYERS:    prdata = APB_DW'(layers_r);
      default:           prdata = '0;
    endcase
  end

  // Tile count is the pixel size rounded up to whole tiles, saturated at the grid limit.
  always_comb begin
    cols_q   = recip_div(DIV_IN_W'(width_r) + DIV_IN_W'(TILE_SIZE - 1), DIV_M, DIV_S);
    rows_q   = recip_div(DIV_IN_W'(height_r) + DIV_IN_W'(TILE_SIZE - 1), DIV_M, DIV_S);
    cols_nxt = (cols_q > QUOT_W'(MAX_TILE_COLS)) ? CNT_W'(MAX_TILE_COLS) : CNT_W'(cols_q);
    rows_nxt = (rows_q > QUOT_W'(MAX_TILE_ROWS)) ? CNT_W'(MAX_TILE_ROWS) : CNT_W'(rows_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= '0;
      rows_r <= '0;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
    end
  end

  always_comb begin
    grid.canvas     = (width_r != '0) && (height_r != '0);
    grid.has_layers = layers_r;
    grid.cols       = cols_r;
    grid.rows       = rows_r;
  end

  assign resize = resize_r;

endmodule

/* hw/rtl/dtt_front.sv */
// Front end: accepts items, converts pixel spans to tile spans and classifies them.
module dtt_front #(
  parameter int TILE_SIZE = dtt_pkg::TILE_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [dtt_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [dtt_pkg::COORD_W-1:0] in_rect_left,
  input  logic signed [dtt_pkg::COORD_W-1:0] in_rect_top,
  input  logic signed [dtt_pkg::COORD_W-1:0] in_rect_right,
  input  logic signed [dtt_pkg::COORD_W-1:0] in_rect_bottom,
  input  logic [dtt_pkg::IDX_W-1:0]         in_tile_col,
  input  logic [dtt_pkg::IDX_W-1:0]         in_tile_row,
  input  dtt_pkg::grid_t                    grid,
  output logic                              cmd_push,
  output dtt_pkg::cmd_t                     cmd,
  input  logic                              cmd_full
);
  import dtt_pkg::*;

  localparam int DIV_L = $clog2(TILE_SIZE);
  localparam int DIV_S = DIV_IN_W + DIV_L;
  localparam longint DIV_M_FULL =
    ((longint'(1) << DIV_S) + longint'(TILE_SIZE) - 1) / longint'(TILE_SIZE);
  localparam logic [DIV_MW-1:0] DIV_M = DIV_MW'(DIV_M_FULL);

  // Negative coordinates always land on tile zero, so only the magnitude of
  // non-negative ones goes through the divider.
  function automatic logic [DIV_IN_W-1:0] non_neg(input logic [COORD_W-1:0] x);
    return x[COORD_W-1] ? '0 : DIV_IN_W'(x[COORD_W-2:0]);
  endfunction

  function automatic logic [IDX_W-1:0] clamp_hi(input logic [QUOT_W-1:0] q,
                                                input logic [CNT_W-1:0] lim);
    return (q > QUOT_W'(lim)) ? IDX_W'(lim) : IDX_W'(q);
  endfunction

  logic                a_valid_r;
  mode_t               a_mode_r;
  logic [DIV_IN_W-1:0] a_left_r, a_top_r, a_right_r, a_bottom_r;
  logic [IDX_W-1:0]    a_col_r, a_row_r;

  logic                b_valid_r;
  mode_t               b_mode_r;
  logic [QUOT_W-1:0]   b_qx0_r, b_qy0_r, b_qx1_r, b_qy1_r;
  logic [IDX_W-1:0]    b_col_r, b_row_r;

  logic                accept, a_go, b_go;
  logic [CNT_W-1:0]    cols_m1, rows_m1;
  logic [IDX_W-1:0]    tx0, tx1, ty0, ty1, tx1_c, ty1_c;
  logic [MASK_W-1:0]   span_mask;
  logic                marking, tile_on_grid;

  assign b_go     = b_valid_r && !cmd_full;
  assign a_go     = a_valid_r && (!b_valid_r || b_go);
  assign full     = a_valid_r && !a_go;
  assign accept   = push && !full;
  assign cmd_push = b_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept || (a_valid_r && !a_go);
      b_valid_r <= a_go || (b_valid_r && !b_go);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mode_r   <= mode_t'(in_mode);
      a_left_r   <= non_neg(in_rect_left);
      a_top_r    <= non_neg(in_rect_top);
      a_right_r  <= non_neg(in_rect_right);
      a_bottom_r <= non_neg(in_rect_bottom);
      a_col_r    <= in_tile_col;
      a_row_r    <= in_tile_row;
    end
    if (a_go) begin
      b_mode_r <= a_mode_r;
      b_qx0_r  <= recip_div(a_left_r, DIV_M, DIV_S);
      b_qy0_r  <= recip_div(a_top_r, DIV_M, DIV_S);
      b_qx1_r  <= recip_div(a_right_r, DIV_M, DIV_S);
      b_qy1_r  <= recip_div(a_bottom_r, DIV_M, DIV_S);
      b_col_r  <= a_col_r;
      b_row_r  <= a_row_r;
    end
  end

  always_comb begin
    cols_m1 = grid.cols - CNT_W'(1);
    rows_m1 = grid.rows - CNT_W'(1);
    tx0     = clamp_hi(b_qx0_r, cols_m1);
    ty0     = clamp_hi(b_qy0_r, rows_m1);
    tx1_c   = clamp_hi(b_qx1_r, cols_m1);
    ty1_c   = clamp_hi(b_qy1_r, rows_m1);
    tx1     = (tx1_c < tx0) ? tx0 : tx1_c;
    ty1     = (ty1_c < ty0) ? ty0 : ty1_c;
    for (int c = 0; c < MASK_W; c++) begin
      span_mask[c] = (IDX_W'(c) >= tx0) && (IDX_W'(c) <= tx1);
    end
    marking      = grid.has_layers && grid.canvas;
    tile_on_grid = (CNT_W'(b_col_r) < grid.cols) && (CNT_W'(b_row_r) < grid.rows);

    cmd.op        = OP_EMPTY;
    cmd.row_first = ty0;
    cmd.row_last  = ty1;
    cmd.mask      = span_mask;
    case (b_mode_r)
      MODE_MARK_RECT: begin
        if (marking) cmd.op = OP_MARK_ROWS;
      end
      MODE_MARK_ALL: begin
        if (marking) cmd.op = OP_MARK_ALL;
      end
      MODE_MARK_TILE: begin
        cmd.row_first = b_row_r;
        cmd.row_last  = b_row_r;
        cmd.mask      = MASK_W'(1) << b_col_r;
        if (marking && tile_on_grid) cmd.op = OP_MARK_ROWS;
      end
      MODE_COLLECT: begin
        if (grid.canvas) cmd.op = OP_COLLECT;
      end
      default: begin
        cmd.op = OP_EMPTY;
      end
    endcase
  end

endmodule

/* hw/rtl/dtt_cmdq.sv */
// Short command queue between the front end and the bitmap engine.
module dtt_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  dtt_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output dtt_pkg::cmd_t rd_data,
  output logic          empty
);
  import dtt_pkg::*;

  cmd_t               slot_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_AW:0]   cnt_r;

  assign full    = (cnt_r == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + CMDQ_AW'(1);
      if (rd_en) rd_ptr_r <= rd_ptr_r + CMDQ_AW'(1);
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + (CMDQ_AW + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (CMDQ_AW + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wr_ptr_r] <= wr_data;
  end

endmodule

/* hw/rtl/dtt_back.sv */
// Bitmap engine: walks tile rows through the dirty bitmap and queues the results.
module dtt_back #(
  parameter int MAX_TILE_COLS = dtt_pkg::MAX_TILE_COLS_DEF,
  parameter int MAX_TILE_ROWS = dtt_pkg::MAX_TILE_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       resize,
  input  dtt_pkg::cmd_t              cmd,
  input  logic                       cmd_empty,
  output logic                       cmd_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [dtt_pkg::IDX_W-1:0]  out_row_index,
  output logic [dtt_pkg::MASK_W-1:0] out_dirty_mask,
  output logic                       out_last
);
  import dtt_pkg::*;

  localparam int RW  = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
  localparam int CW  = MAX_TILE_COLS;
  localparam int OCW = OFIFO_AW + 2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r;
  logic [RW-1:0]     row_r, last_row_r;
  logic [CW-1:0]     mask_r;

  logic [CW-1:0]     mem [MAX_TILE_ROWS];
  logic [CW-1:0]     rd_data_r;
  logic [MAX_TILE_ROWS-1:0] valid_r;

  logic              s2_valid_r, s2_emit_r, s2_last_r;
  op_t               s2_op_r;
  logic [RW-1:0]     s2_row_r;

  res_t              ofifo_r [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] of_wr_r, of_rd_r;
  logic [OFIFO_AW:0] of_cnt_r;

  logic              at_last, room, issue, done, clear_all, s2_wr, of_push, of_pop;
  logic [CW-1:0]     row_val, wdata;
  res_t              res;

  assign at_last   = (row_r == last_row_r);
  assign room      = (OCW'(of_cnt_r) + OCW'(s2_valid_r && s2_emit_r)) < OCW'(OFIFO_DEPTH);
  assign issue     = (state_r == ST_RUN) && room;
  assign done      = issue && ((op_r == OP_EMPTY) || (op_r == OP_MARK_ALL) || at_last);
  assign cmd_pop   = (state_r == ST_IDLE) && !resize && !cmd_empty;
  assign clear_all = ((state_r == ST_IDLE) && resize) || (issue && (op_r == OP_MARK_ALL));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd_pop) state_nxt = ST_RUN;
      ST_RUN:  if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s2_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s2_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op_r       <= cmd.op;
      row_r      <= cmd.row_first[RW-1:0];
      last_row_r <= cmd.row_last[RW-1:0];
      mask_r     <= cmd.mask[CW-1:0];
    end else if (issue) begin
      row_r <= row_r + RW'(1);
    end
    if (issue) begin
      s2_op_r   <= op_r;
      s2_row_r  <= row_r;
      s2_emit_r <= (op_r != OP_MARK_ROWS) || at_last;
      s2_last_r <= (op_r != OP_COLLECT) || at_last;
    end
  end

  // A row whose valid bit is clear has not been written since the bitmap was
  // last filled, and reads as all dirty.
  always_comb begin
    row_val = valid_r[s2_row_r] ? rd_data_r : {CW{1'b1}};
    res.row_index  = '0;
    res.dirty_mask = '0;
    res.last       = s2_last_r;
    case (s2_op_r)
      OP_COLLECT: begin
        wdata          = row_val & ~mask_r;
        res.row_index  = IDX_W'(s2_row_r);
        res.dirty_mask = MASK_W'(row_val & mask_r);
      end
      OP_MARK_ROWS: wdata = row_val | mask_r;
      default:      wdata = row_val;
    endcase
  end

  assign s2_wr   = s2_valid_r && ((s2_op_r == OP_COLLECT) || (s2_op_r == OP_MARK_ROWS));
  assign of_push = s2_valid_r && s2_emit_r;
  assign of_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (issue) rd_data_r <= mem[row_r];
    if (s2_wr) mem[s2_row_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clear_all) begin
      valid_r <= '0;
    end else if (s2_wr) begin
      valid_r[s2_row_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_r  <= '0;
      of_rd_r  <= '0;
      of_cnt_r <= '0;
    end else begin
      if (of_push) of_wr_r <= of_wr_r + OFIFO_AW'(1);
      if (of_pop)  of_rd_r <= of_rd_r + OFIFO_AW'(1);
      case ({of_push, of_pop})
        2'b10:   of_cnt_r <= of_cnt_r + (OFIFO_AW + 1)'(1);
        2'b01:   of_cnt_r <= of_cnt_r - (OFIFO_AW + 1)'(1);
        default: of_cnt_r <= of_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (of_push) ofifo_r[of_wr_r] <= res;
  end

  assign empty          = (of_cnt_r == '0);
  assign out_row_index  = ofifo_r[of_rd_r].row_index;
  assign out_dirty_mask = ofifo_r[of_rd_r].dirty_mask;
  assign out_last       = ofifo_r[of_rd_r].last;

endmodule

/* hw/rtl/dirty_tile_tracker.sv */
// Top level of the dirty tile tracker: one dirty bit per canvas tile.
//
// Items arrive through a queue-like input channel (push/full) and results leave
// through a queue-like output channel (empty/pop). An item is taken on each edge
// where push is high and full is low; a result is taken on each edge where pop is
// high and empty is low. A collect on a canvas gives one transfer per tile row it
// covers, with the last flag set on the final one; every other item, and a collect
// with no canvas, gives a single empty result. The front end registers the clipped
// coordinates, then their quotients by the tile size, turns those into tile spans
// and hands a command to a two-entry queue. The bitmap engine picks up a command
// when idle, then walks one tile row per cycle while the result queue has room.
// The row rate is set by the read-modify-write pass over the bitmap memory. Reset
// puts the control state in idle and leaves every tile dirty; that state costs no
// clearing pass because each bitmap row carries a valid bit. Writing the canvas
// width or height while the engine idles marks every tile dirty again likewise.
// When the receiver stalls, a four-entry result queue fills and the engine pauses;
// the front end keeps taking items until its own stages and the command queue fill.
// Configuration goes through an APB-style port, which the user must write only while
// the block idles; the block itself does not enforce this.
module dirty_tile_tracker #(
  parameter int TILE_SIZE     = dtt_pkg::TILE_SIZE_DEF,
  parameter int MAX_TILE_COLS = dtt_pkg::MAX_TILE_COLS_DEF,
  parameter int MAX_TILE_ROWS = dtt_pkg::MAX_TILE_ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [dtt_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [dtt_pkg::COORD_W-1:0] in_rect_left,
  input  logic signed [dtt_pkg::COORD_W-1:0] in_rect_top,
  input  logic signed [dtt_pkg::COORD_W-1:0] in_rect_right,
  input  logic signed [dtt_pkg::COORD_W-1:0] in_rect_bottom,
  input  logic [dtt_pkg::IDX_W-1:0]          in_tile_col,
  input  logic [dtt_pkg::IDX_W-1:0]          in_tile_row,
  output logic                               empty,
  input  logic                               pop,
  output logic [dtt_pkg::IDX_W-1:0]          out_row_index,
  output logic [dtt_pkg::MASK_W-1:0]         out_dirty_mask,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dtt_pkg::APB_AW-1:0]         paddr,
  input  logic [dtt_pkg::APB_DW-1:0]         pwdata,
  output logic [dtt_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import dtt_pkg::*;

  grid_t grid;
  logic  resize;
  logic  cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t  cmd_in, cmd_out;

  // Register file and the tile grid size derived from the canvas size.
  dtt_cfg #(
    .TILE_SIZE    (TILE_SIZE),
    .MAX_TILE_COLS(MAX_TILE_COLS),
    .MAX_TILE_ROWS(MAX_TILE_ROWS)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .grid   (grid),
    .resize (resize)
  );

  // Front end: accepts items and turns them into row-walk commands.
  dtt_front #(
    .TILE_SIZE(TILE_SIZE)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_mode       (in_mode),
    .in_rect_left  (in_rect_left),
    .in_rect_top   (in_rect_top),
    .in_rect_right (in_rect_right),
    .in_rect_bottom(in_rect_bottom),
    .in_tile_col   (in_tile_col),
    .in_tile_row   (in_tile_row),
    .grid          (grid),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .cmd_full      (cmd_full)
  );

  // The command queue lets the front end run ahead of a long collect.
  dtt_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_data(cmd_in),
    .full   (cmd_full),
    .rd_en  (cmd_pop),
    .rd_data(cmd_out),
    .empty  (cmd_empty)
  );

  // Bitmap engine with its memory and result queue.
  dtt_back #(
    .MAX_TILE_COLS(MAX_TILE_COLS),
    .MAX_TILE_ROWS(MAX_TILE_ROWS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .resize        (resize),
    .cmd           (cmd_out),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .out_row_index (out_row_index),
    .out_dirty_mask(out_dirty_mask),
    .out_last      (out_last)
  );

endmodule
